>>> hw/rtl/sukt_pkg.sv
// Shared definitions for the sorted unique key table.
// Request and status codes, and the control word broadcast to the cell row.
// No dependencies.
`default_nettype none

package sukt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } sukt_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sukt_cell.sv
// One cell of the key row: holds a single key, compares it with the request key
// and shifts left or right on a remove or insert. Depends on sukt_pkg.
`default_nettype none

module sukt_cell
    import sukt_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  wire                 clk,
    input  wire                 cmp_en,
    input  wire  [KEY_BITS-1:0] cmp_key,
    input  wire                 occupied,
    input  wire  sukt_ctrl_t    ctrl,
    input  wire  [KEY_BITS-1:0] new_key,
    input  wire  [KEY_BITS-1:0] left_key,
    input  wire                 left_lt,
    input  wire  [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0] key_out,
    output logic                lt_out,
    output logic                eq_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                lt_reg;
    logic                eq_reg;

    always_comb
    begin
        key_next = key_reg;
        // Cells below the insertion point keep their key; the first cell at or
        // above it takes the new key and every later one takes its left neighbour.
        if (ctrl.ins && !lt_reg)
        begin
            key_next = left_lt ? new_key : left_key;
        end
        else if (ctrl.rem && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmp_en)
        begin
            lt_reg <= occupied && ($signed(key_reg) < $signed(cmp_key));
            eq_reg <= occupied && (key_reg == cmp_key);
        end
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_unique_key_table.sv
// The table keeps up to CAPACITY distinct signed keys in ascending order, one key
// per cell in a row of compare-and-shift cells. Each request beat (insert, remove or
// lookup) returns one beat with a status and the entry count after the request. In
// the cycle a request is accepted every cell compares its key with the request key,
// and in the update state the match flags are combined and the row shifts in one
// step to insert or close the gap. No new request is accepted until the previous
// one has been committed; the update waits only while a previous result is still
// held in the output register. There is no clearing pass after reset.
// Depends on sukt_pkg and sukt_cell.
`default_nettype none

module sorted_unique_key_table
    import sukt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32,
    localparam int CNT_BITS = $clog2(CAPACITY + 1)
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  [1:0]          op,
    input  wire  [KEY_BITS-1:0] key,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [1:0]          status,
    output logic [CNT_BITS-1:0] entry_count
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;

    logic                accept;
    logic                commit;
    logic                present;
    logic                full;
    sukt_ctrl_t          ctrl;

    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign commit  = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign present = |eq_vec;
    assign full    = (count_reg == CNT_BITS'(CAPACITY));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_lt;
            logic [KEY_BITS-1:0] right_key;

            if (gi == 0)
            begin : g_first
                assign left_key = key_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_inner_left
                assign left_key = cell_key[gi-1];
                assign left_lt  = lt_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key = cell_key[gi];
            end
            else
            begin : g_inner_right
                assign right_key = cell_key[gi+1];
            end

            sukt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .cmp_en    (accept),
                .cmp_key   (key),
                .occupied  (CNT_BITS'(gi) < count_reg),
                .ctrl      (ctrl),
                .new_key   (key_reg),
                .left_key  (left_key),
                .left_lt   (left_lt),
                .right_key (right_key),
                .key_out   (cell_key[gi]),
                .lt_out    (lt_vec[gi]),
                .eq_out    (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl        = '0;
        status_next = status_reg;
        count_next  = count_reg;
        if (commit)
        begin
            unique case (op_reg)
                OP_INSERT:
                begin
                    if (present)
                    begin
                        status_next = STATUS_ABSENT;
                    end
                    else if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        ctrl.ins    = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (present)
                    begin
                        status_next = STATUS_OK;
                        ctrl.rem    = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_ABSENT;
                    end
                end
                default:
                begin
                    // Lookup, and the unused code, leave the table alone.
                    status_next = present ? STATUS_OK : STATUS_ABSENT;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= key;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && ctrl.ins) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table by one");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL)) |-> (entry_count == CNT_BITS'(CAPACITY)))
        else $error("full status with spare room");
`endif

endmodule

`default_nettype wire
